### hdl/nau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nau_pkg
// Shared constants, codes and types of the accumulator update block.
// ----------------------------------------------------------------------------
package nau_pkg;

	localparam int FEATURES = 768;
	localparam int OUTPUTS  = 256;
	localparam int LANES    = 16;

	localparam int W_W      = 16;
	localparam int ACC_W    = 32;
	localparam int KIND_W   = 3;
	localparam int FEAT_W   = 10;
	localparam int COL_W    = 8;
	localparam int ACT_W    = 9;

	localparam int ROWS     = OUTPUTS / LANES;
	localparam int LANE_W   = $clog2(LANES);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int IDX_W    = ROW_W + LANE_W;
	localparam int N_W      = IDX_W + 1;
	localparam int AROW_W   = ROW_W + 1;
	localparam int SF_W     = $clog2(2 * FEATURES);
	localparam int WDEPTH   = 2 * FEATURES * ROWS;
	localparam int WA_W     = $clog2(WDEPTH);
	localparam int ADEPTH   = 2 * ROWS;
	localparam int AA_W     = $clog2(ADEPTH);

	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_LOAD_W  = 3'd0;
	localparam kind_t KIND_LOAD_B  = 3'd1;
	localparam kind_t KIND_REFRESH = 3'd2;
	localparam kind_t KIND_ADD     = 3'd3;
	localparam kind_t KIND_SUB     = 3'd4;
	localparam kind_t KIND_READ    = 3'd5;

	typedef logic [LANES-1:0][ACC_W-1:0] acc_row_t;
	typedef logic [LANES-1:0][W_W-1:0]   w_row_t;

	typedef struct packed {
		logic             refresh;
		logic             sub;
		logic [LANES-1:0] mask;
	} alu_ctrl_t;

endpackage

### hdl/nau_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nau_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nau_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/nau_lane_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nau_lane_alu
// Per-lane refresh / saturating add / saturating subtract with lane merge.
// ----------------------------------------------------------------------------
module nau_lane_alu (
	input  nau_pkg::alu_ctrl_t ctrl,
	input  nau_pkg::acc_row_t  acc_in,
	input  nau_pkg::w_row_t    w_in,
	input  nau_pkg::w_row_t    b_in,
	output nau_pkg::acc_row_t  acc_out,
	output logic               sat
);
	import nau_pkg::*;

	logic [LANES-1:0] lane_sat;

	always_comb begin
		logic signed [ACC_W:0] a;
		logic signed [ACC_W:0] w;
		logic signed [ACC_W:0] s;
		for (int l = 0; l < LANES; l++) begin
			a = (ACC_W+1)'(signed'(acc_in[l]));
			w = (ACC_W+1)'(signed'(w_in[l]));
			s = ctrl.sub ? a - w : a + w;
			lane_sat[l] = 1'b0;
			acc_out[l] = acc_in[l];
			if (ctrl.mask[l]) begin
				if (ctrl.refresh) begin
					acc_out[l] = ACC_W'(signed'(b_in[l]));
				end else if (s[ACC_W] != s[ACC_W-1]) begin
					// overflow: clamp towards the sign of the true sum
					lane_sat[l] = 1'b1;
					acc_out[l] = {s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
				end else begin
					acc_out[l] = s[ACC_W-1:0];
				end
			end
		end
	end

	assign sat = |lane_sat;

endmodule

### hdl/nnue_accumulator_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnue_accumulator_update
// Two-perspective first-layer accumulator keeper with saturating updates.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Loads of a weight or bias word are written
// as they are accepted. Refresh, add and remove walk the active columns
// sixteen at a time through one wide accumulator RAM row per cycle, with a
// registered read-modify-write. A read waits in the read state for the
// output register to drain. The accumulators need no clearing pass: a valid
// bit per 16-column row makes an unwritten row read as zero. The saturated
// output is the sticky flag as it stood when the read item was handled.
module nnue_accumulator_update (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [nau_pkg::ACT_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [nau_pkg::KIND_W-1:0]  kind,
	input  logic                        side,
	input  logic [nau_pkg::FEAT_W-1:0]  feature,
	input  logic [nau_pkg::COL_W-1:0]   column,
	input  logic signed [15:0]          value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          acc_value,
	output logic                        side_echo,
	output logic [nau_pkg::COL_W-1:0]   column_echo,
	output logic                        saturated
);
	import nau_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_READ  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [ACT_W-1:0]     active_q;
	logic [N_W-1:0]       n_live;
	logic [AROW_W-1:0]    nrows;
	logic                 accept;
	logic [SF_W-1:0]      sf_in;
	logic                 feat_ok;
	logic                 col_ok;
	logic [ROW_W-1:0]     col_row;
	logic                 go_walk;

	// item held for the walk / read
	kind_t                kind_q;
	logic                 side_q;
	logic [SF_W-1:0]      sf_q;
	logic [COL_W-1:0]     column_q;
	logic [ROW_W-1:0]     row_q;
	logic [AROW_W-1:0]    nrows_q;

	// write-back stage
	logic                 valid_s1;
	logic [ROW_W-1:0]     row_s1;
	logic                 vld_s1;

	logic [ADEPTH-1:0]    acc_vld_q;
	logic                 sat_q;

	logic                 walk_issue;
	logic                 read_issue;
	logic [AA_W-1:0]      acc_raddr;
	acc_row_t             acc_rdata;
	acc_row_t             acc_cur;
	acc_row_t             acc_new;
	w_row_t               w_rdata;
	w_row_t               b_rdata;
	alu_ctrl_t            alu_ctrl;
	logic                 alu_sat;
	logic                 out_free;

	// live column count, clipped to the array size
	assign n_live = (32'(active_q) > OUTPUTS) ? N_W'(OUTPUTS) : N_W'(active_q);
	assign nrows  = AROW_W'((32'(n_live) + LANES - 1) >> LANE_W);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign sf_in    = (side ? SF_W'(FEATURES) : '0) + SF_W'(feature);
	assign feat_ok  = 32'(feature) < FEATURES;
	assign col_ok   = 32'(column) < OUTPUTS;
	assign col_row  = ROW_W'(column >> LANE_W);
	assign go_walk  = (nrows != '0) && ((kind == KIND_REFRESH) ||
		(((kind == KIND_ADD) || (kind == KIND_SUB)) && feat_ok));

	assign walk_issue = (state_q == S_WALK);
	assign read_issue = accept && (kind == KIND_READ);
	assign acc_raddr  = walk_issue ? {side_q, row_q} : {side, col_row};
	assign out_free   = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_W'(256);
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					row_q <= '0;
					if (accept && go_walk) begin
						state_q <= S_WALK;
					end else if (read_issue) begin
						state_q <= S_READ;
					end
				end
				S_WALK: begin
					row_q <= row_q + 1'b1;
					if (AROW_W'(row_q) + 1'b1 == nrows_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			side_q   <= side;
			sf_q     <= sf_in;
			column_q <= column;
			nrows_q  <= nrows;
		end
		row_s1 <= row_q;
		if (walk_issue || read_issue) begin
			vld_s1 <= acc_vld_q[acc_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			acc_vld_q <= '0;
			sat_q     <= 1'b0;
		end else begin
			valid_s1 <= walk_issue;
			if (valid_s1) begin
				acc_vld_q[{side_q, row_s1}] <= 1'b1;
				sat_q <= sat_q | alu_sat;
			end
		end
	end

	// weight and bias stores: one narrow RAM per lane so a single word loads
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		nau_ram #(.WIDTH(W_W), .DEPTH(WDEPTH)) u_wram (
			.clk   (clk),
			.we    (accept && (kind == KIND_LOAD_W) && feat_ok && col_ok &&
			        (column[LANE_W-1:0] == LANE_W'(l))),
			.waddr (WA_W'({sf_in, col_row})),
			.wdata (value),
			.re    (walk_issue),
			.raddr (WA_W'({sf_q, row_q})),
			.rdata (w_rdata[l])
		);
		nau_ram #(.WIDTH(W_W), .DEPTH(ADEPTH)) u_bram (
			.clk   (clk),
			.we    (accept && (kind == KIND_LOAD_B) && col_ok &&
			        (column[LANE_W-1:0] == LANE_W'(l))),
			.waddr ({side, col_row}),
			.wdata (value),
			.re    (walk_issue),
			.raddr ({side_q, row_q}),
			.rdata (b_rdata[l])
		);
	end

	nau_ram #(.WIDTH(LANES * ACC_W), .DEPTH(ADEPTH)) u_aram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr ({side_q, row_s1}),
		.wdata (acc_new),
		.re    (walk_issue || read_issue),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	// rows never written since reset read as zero
	assign acc_cur = vld_s1 ? acc_rdata : '0;

	always_comb begin
		alu_ctrl.refresh = (kind_q == KIND_REFRESH);
		alu_ctrl.sub     = (kind_q == KIND_SUB);
		for (int l = 0; l < LANES; l++) begin
			alu_ctrl.mask[l] = ({1'b0, row_s1, LANE_W'(l)} < (IDX_W+1)'(n_live));
		end
	end

	nau_lane_alu u_alu (
		.ctrl    (alu_ctrl),
		.acc_in  (acc_cur),
		.w_in    (w_rdata),
		.b_in    (b_rdata),
		.acc_out (acc_new),
		.sat     (alu_sat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_READ) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_READ) && out_free) begin
			acc_value   <= (32'(column_q) < OUTPUTS) ?
				signed'(acc_cur[column_q[LANE_W-1:0]]) : '0;
			side_echo   <= side_q;
			column_echo <= column_q;
			saturated   <= sat_q;
		end
	end

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == S_WALK || state_q == S_DRAIN))
		else $error("write-back outside a walk");
	a_idle_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !valid_s1)
		else $error("item accepted with write-back pending");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (AROW_W'(row_q) < nrows_q))
		else $error("walk row past active rows");
	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(sat_q) |-> sat_q)
		else $error("saturation flag cleared");

endmodule
